>>> src/fab_pkg.sv
// Shared types, codes and defaults for the file block allocator.
// Used by the controller, the datapath and the top level.
package fab_pkg;

  // default sizing
  localparam int DEF_INODE_COUNT     = 128;
  localparam int DEF_DATA_BLOCKS     = 4096;
  localparam int DEF_BLOCKS_PER_FILE = 64;
  localparam int DEF_BLOCK_BYTES     = 8192;

  // free map is kept as words of this many block bits
  localparam int MAP_WORD = 16;
  localparam int MAP_BITW = 4;

  // command codes
  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_ATTR   = 3'd2;
  localparam logic [2:0] CMD_LOOKUP = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  // attribute codes
  localparam logic [1:0] ATTR_SET_HID = 2'd0;
  localparam logic [1:0] ATTR_CLR_HID = 2'd1;
  localparam logic [1:0] ATTR_SET_RO  = 2'd2;
  localparam logic [1:0] ATTR_CLR_RO  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOSPACE  = 3'd1;
  localparam logic [2:0] ST_TOOLARGE = 3'd2;
  localparam logic [2:0] ST_NOINODE  = 3'd3;
  localparam logic [2:0] ST_NOTUSED  = 3'd4;
  localparam logic [2:0] ST_RDONLY   = 3'd5;
  localparam logic [2:0] ST_NOSLOT   = 3'd6;

  // where the fields of a result word come from
  localparam logic [2:0] SRC_ZERO    = 3'd0;
  localparam logic [2:0] SRC_SEL     = 3'd1;
  localparam logic [2:0] SRC_REC     = 3'd2;
  localparam logic [2:0] SRC_REC_BLK = 3'd3;
  localparam logic [2:0] SRC_NEW     = 3'd4;
  localparam logic [2:0] SRC_NEW_BLK = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       clr_step;
    logic       ino_inc;
    logic       ino_take;
    logic       map_rd;
    logic       map_blk;
    logic       map_load;
    logic       alloc;
    logic       wptr_inc;
    logic       list_rd;
    logic       list_new;
    logic       list_slot;
    logic       k_inc;
    logic       k_clr;
    logic       rec_rd;
    logic       rec_load;
    logic       attr_wr;
    logic       blk_load;
    logic       free_bit;
    logic       del_commit;
    logic       out_load;
    logic [2:0] out_src;
    logic [2:0] out_status;
    logic       out_last;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic nospace;
    logic toolarge;
    logic need_zero;
    logic ino_free;
    logic ino_last;
    logic word_free;
    logic k_last_new;
    logic k_last_del;
    logic len_zero;
    logic sel_ok;
    logic rec_ro;
    logic slot_bad;
    logic out_free;
  } sts_t;

endpackage

>>> src/fab_ram.sv
// Generic single write port RAM with one registered read port.
// No package dependencies.
module fab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> src/fab_datapath.sv
// Datapath: inode map, free map, block list and inode records, output register.
// Depends on fab_pkg and fab_ram.
module fab_datapath #(
  parameter int INODE_COUNT     = fab_pkg::DEF_INODE_COUNT,
  parameter int DATA_BLOCKS     = fab_pkg::DEF_DATA_BLOCKS,
  parameter int BLOCKS_PER_FILE = fab_pkg::DEF_BLOCKS_PER_FILE,
  parameter int BLOCK_BYTES     = fab_pkg::DEF_BLOCK_BYTES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fab_pkg::ctl_t ctl,
  output fab_pkg::sts_t sts,
  input  logic [25:0]   in_file_bytes,
  input  logic [6:0]    in_inode_sel,
  input  logic [1:0]    in_attr_code,
  input  logic [5:0]    in_block_slot,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [6:0]    out_inode_out,
  output logic [11:0]   out_block_number,
  output logic          out_block_valid,
  output logic [25:0]   out_free_bytes,
  output logic [19:0]   out_file_size,
  output logic          out_hidden,
  output logic          out_read_only,
  output logic          out_last
);
  import fab_pkg::*;

  localparam int IW   = (INODE_COUNT > 1) ? $clog2(INODE_COUNT) : 1;
  localparam int BBW  = $clog2(DATA_BLOCKS);
  localparam int CW   = $clog2(DATA_BLOCKS + 1);
  localparam int BBL  = $clog2(BLOCK_BYTES);
  localparam int LENW = $clog2(BLOCKS_PER_FILE + 1);
  localparam int MW   = DATA_BLOCKS / MAP_WORD;
  localparam int MAW  = (MW > 1) ? $clog2(MW) : 1;
  localparam int LD   = INODE_COUNT * BLOCKS_PER_FILE;
  localparam int LAW  = (LD > 1) ? $clog2(LD) : 1;
  localparam int RW   = 20 + LENW + 2;

  typedef struct packed {
    logic [19:0]     size;
    logic [LENW-1:0] len;
    logic            hid;
    logic            ro;
  } rec_t;

  // latched input word
  logic [25:0] bytes_r;
  logic [6:0]  sel_r;
  logic [1:0]  attr_r;
  logic [5:0]  slot_r;

  logic [INODE_COUNT-1:0] inode_used_r;
  logic [IW-1:0]          ino_r;
  logic [LENW-1:0]        k_r;
  logic [MAW-1:0]         wptr_r;
  logic [MAW-1:0]         clr_r;
  logic                   clr_busy_r;
  logic [CW-1:0]          cnt_r;
  logic [MAP_WORD-1:0]    word_r;
  logic [BBW-1:0]         blk_r;
  rec_t                   rec_r;

  logic                   out_valid_r;
  logic [2:0]             status_r;
  logic [6:0]             inode_out_r;
  logic [11:0]            blk_out_r;
  logic                   blk_valid_r;
  logic [25:0]            free_out_r;
  logic [19:0]            size_out_r;
  logic                   hid_out_r;
  logic                   ro_out_r;
  logic                   last_out_r;

  logic [IW-1:0]          sel_idx;
  logic [63:0]            free_wide;
  logic [26:0]            need_full;
  logic [LENW-1:0]        need;
  logic [MAP_BITW-1:0]    fz;

  // memory ports
  logic                   map_we;
  logic [MAW-1:0]         map_addr;
  logic [MAP_WORD-1:0]    map_wdata;
  logic [MAP_WORD-1:0]    map_rdata;
  logic [LAW-1:0]         list_addr;
  logic [BBW-1:0]         list_wdata;
  logic [BBW-1:0]         list_rdata;
  logic                   rec_we;
  logic [IW-1:0]          rec_addr;
  rec_t                   rec_wdata;
  rec_t                   rec_rdata;
  rec_t                   rec_mod;
  logic [IW-1:0]          list_base;
  logic [LENW-1:0]        list_off;

  assign sel_idx   = IW'(sel_r);
  assign free_wide = 64'(cnt_r) << BBL;
  assign need_full = (27'(bytes_r) + 27'(BLOCK_BYTES - 1)) >> BBL;
  assign need      = LENW'(need_full);

  // lowest free bit of the current map word
  always_comb begin
    fz = '0;
    for (int i = MAP_WORD - 1; i >= 0; i--) begin
      if (!word_r[i]) fz = MAP_BITW'(i);
    end
  end

  // attribute update
  always_comb begin
    rec_mod = rec_r;
    case (attr_r)
      ATTR_SET_HID: rec_mod.hid = 1'b1;
      ATTR_CLR_HID: rec_mod.hid = 1'b0;
      ATTR_SET_RO:  rec_mod.ro  = 1'b1;
      default:      rec_mod.ro  = 1'b0;
    endcase
  end

  // free map port: clearing pass, allocation or release
  always_comb begin
    map_we    = ctl.clr_step | ctl.alloc | ctl.free_bit;
    map_addr  = wptr_r;
    map_wdata = word_r | (MAP_WORD'(1) << fz);
    if (ctl.clr_step) begin
      map_addr  = clr_r;
      map_wdata = '0;
    end else if (ctl.map_blk || ctl.free_bit) begin
      map_addr  = MAW'(blk_r >> MAP_BITW);
      map_wdata = map_rdata & ~(MAP_WORD'(1) << blk_r[MAP_BITW-1:0]);
    end
  end

  // block list port
  assign list_base  = ctl.list_new ? ino_r : sel_idx;
  assign list_off   = ctl.list_slot ? LENW'(slot_r) : k_r;
  assign list_addr  = LAW'(32'(list_base) * BLOCKS_PER_FILE + 32'(list_off));
  assign list_wdata = BBW'({wptr_r, fz});

  // inode record port
  always_comb begin
    rec_we    = ctl.ino_take | ctl.attr_wr;
    rec_addr  = ctl.ino_take ? ino_r : sel_idx;
    rec_wdata = rec_mod;
    if (ctl.ino_take) begin
      rec_wdata.size = bytes_r[19:0];
      rec_wdata.len  = need;
      rec_wdata.hid  = 1'b0;
      rec_wdata.ro   = 1'b0;
    end
  end

  fab_ram #(.WIDTH(MAP_WORD), .DEPTH(MW)) u_map (
    .clk(clk), .we(map_we), .waddr(map_addr), .wdata(map_wdata),
    .re(ctl.map_rd), .raddr(map_addr), .rdata(map_rdata)
  );

  fab_ram #(.WIDTH(BBW), .DEPTH(LD)) u_list (
    .clk(clk), .we(ctl.alloc), .waddr(list_addr), .wdata(list_wdata),
    .re(ctl.list_rd), .raddr(list_addr), .rdata(list_rdata)
  );

  fab_ram #(.WIDTH(RW), .DEPTH(INODE_COUNT)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_addr), .wdata(rec_wdata),
    .re(ctl.rec_rd), .raddr(rec_addr), .rdata(rec_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inode_used_r <= '0;
      cnt_r        <= CW'(DATA_BLOCKS);
      clr_r        <= '0;
      clr_busy_r   <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (ctl.clr_step) begin
        clr_r <= clr_r + MAW'(1);
        if (32'(clr_r) == MW - 1) clr_busy_r <= 1'b0;
      end
      if (ctl.ino_take)   inode_used_r[ino_r]   <= 1'b1;
      if (ctl.del_commit) inode_used_r[sel_idx] <= 1'b0;
      if (ctl.alloc)      cnt_r <= cnt_r - CW'(1);
      if (ctl.free_bit)   cnt_r <= cnt_r + CW'(1);
      if (ctl.out_load)   out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      bytes_r <= in_file_bytes;
      sel_r   <= in_inode_sel;
      attr_r  <= in_attr_code;
      slot_r  <= in_block_slot;
      ino_r   <= '0;
      wptr_r  <= '0;
    end
    if (ctl.ino_inc)  ino_r  <= ino_r + IW'(1);
    if (ctl.wptr_inc) wptr_r <= wptr_r + MAW'(1);
    if (ctl.latch || ctl.k_clr) k_r <= '0;
    else if (ctl.k_inc || ctl.alloc) k_r <= k_r + LENW'(1);
    if (ctl.map_load) word_r <= map_rdata;
    else if (ctl.alloc) word_r <= map_wdata;
    if (ctl.blk_load) blk_r <= list_rdata;
    if (ctl.rec_load) rec_r <= rec_rdata;
    else if (ctl.attr_wr) rec_r <= rec_mod;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status_r    <= ctl.out_status;
      last_out_r  <= ctl.out_last;
      free_out_r  <= free_wide[25:0];
      inode_out_r <= '0;
      blk_out_r   <= '0;
      blk_valid_r <= 1'b0;
      size_out_r  <= '0;
      hid_out_r   <= 1'b0;
      ro_out_r    <= 1'b0;
      case (ctl.out_src) inside
        SRC_SEL: begin
          inode_out_r <= sel_r;
        end
        SRC_REC, SRC_REC_BLK: begin
          inode_out_r <= sel_r;
          size_out_r  <= rec_r.size;
          hid_out_r   <= rec_r.hid;
          ro_out_r    <= rec_r.ro;
        end
        SRC_NEW, SRC_NEW_BLK: begin
          inode_out_r <= 7'(ino_r);
          size_out_r  <= bytes_r[19:0];
        end
        default: ;
      endcase
      if (ctl.out_src == SRC_REC_BLK || ctl.out_src == SRC_NEW_BLK) begin
        blk_out_r   <= 12'(list_rdata);
        blk_valid_r <= 1'b1;
      end
    end
  end

  // status to controller
  always_comb begin
    sts.clr_done   = !clr_busy_r || (32'(clr_r) == MW - 1);
    sts.nospace    = 64'(bytes_r) > free_wide;
    sts.toolarge   = 32'(need_full) > BLOCKS_PER_FILE;
    sts.need_zero  = (need == '0);
    sts.ino_free   = !inode_used_r[ino_r];
    sts.ino_last   = (32'(ino_r) == INODE_COUNT - 1);
    sts.word_free  = !(&word_r);
    sts.k_last_new = ((k_r + LENW'(1)) == need);
    sts.k_last_del = ((k_r + LENW'(1)) == rec_r.len);
    sts.len_zero   = (rec_r.len == '0);
    sts.sel_ok     = (32'(sel_r) < INODE_COUNT) && inode_used_r[sel_idx];
    sts.rec_ro     = rec_r.ro;
    sts.slot_bad   = (32'(slot_r) >= 32'(rec_r.len)) || (32'(slot_r) >= BLOCKS_PER_FILE);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_inode_out    = inode_out_r;
  assign out_block_number = blk_out_r;
  assign out_block_valid  = blk_valid_r;
  assign out_free_bytes   = free_out_r;
  assign out_file_size    = size_out_r;
  assign out_hidden       = hid_out_r;
  assign out_read_only    = ro_out_r;
  assign out_last         = last_out_r;
endmodule

>>> src/fab_ctrl.sv
// Controller state machine: sequences clearing, create, delete, attribute,
// lookup and query over the datapath. Depends on fab_pkg.
module fab_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_cmd,
  input  fab_pkg::sts_t sts,
  output fab_pkg::ctl_t ctl
);
  import fab_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_ISCAN = 4'd3;
  localparam logic [3:0] S_MRD   = 4'd4;
  localparam logic [3:0] S_MLD   = 4'd5;
  localparam logic [3:0] S_ALLOC = 4'd6;
  localparam logic [3:0] S_ELRD  = 4'd7;
  localparam logic [3:0] S_RWAIT = 4'd8;
  localparam logic [3:0] S_RCHK  = 4'd9;
  localparam logic [3:0] S_DLRD  = 4'd10;
  localparam logic [3:0] S_DBLK  = 4'd11;
  localparam logic [3:0] S_DMRD  = 4'd12;
  localparam logic [3:0] S_DFREE = 4'd13;
  localparam logic [3:0] S_DFIN  = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic [2:0] cmd_r;
  logic [2:0] src_r, src_nxt;
  logic [2:0] stat_r, stat_nxt;
  logic       last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) cmd_r <= in_cmd;
    src_r  <= src_nxt;
    stat_r <= stat_nxt;
    last_r <= last_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    src_nxt        = src_r;
    stat_nxt       = stat_r;
    last_nxt       = last_r;
    ctl            = '0;
    ctl.out_src    = src_r;
    ctl.out_status = stat_r;
    ctl.out_last   = last_r;
    unique case (state_r)
      S_CLR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_OUT;
        last_nxt  = 1'b1;
        src_nxt   = SRC_ZERO;
        stat_nxt  = ST_OK;
        unique case (cmd_r) inside
          CMD_CREATE: begin
            if (sts.nospace)       stat_nxt = ST_NOSPACE;
            else if (sts.toolarge) stat_nxt = ST_TOOLARGE;
            else                   state_nxt = S_ISCAN;
          end
          CMD_QUERY: ;
          CMD_DELETE, CMD_ATTR, CMD_LOOKUP: begin
            if (sts.sel_ok) begin
              ctl.rec_rd = 1'b1;
              state_nxt  = S_RWAIT;
            end else begin
              src_nxt  = SRC_SEL;
              stat_nxt = ST_NOTUSED;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // lowest free inode, one per cycle
      S_ISCAN: begin
        if (sts.ino_free) begin
          ctl.ino_take = 1'b1;
          if (sts.need_zero) begin
            src_nxt   = SRC_NEW;
            stat_nxt  = ST_OK;
            last_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_MRD;
          end
        end else if (sts.ino_last) begin
          src_nxt   = SRC_ZERO;
          stat_nxt  = ST_NOINODE;
          last_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          ctl.ino_inc = 1'b1;
        end
      end
      S_MRD: begin
        ctl.map_rd = 1'b1;
        state_nxt  = S_MLD;
      end
      S_MLD: begin
        ctl.map_load = 1'b1;
        state_nxt    = S_ALLOC;
      end
      // one block per cycle out of the current map word
      S_ALLOC: begin
        if (sts.word_free) begin
          ctl.alloc    = 1'b1;
          ctl.list_new = 1'b1;
          if (sts.k_last_new) begin
            ctl.k_clr = 1'b1;
            ctl.alloc = 1'b1;
            state_nxt = S_ELRD;
          end
        end else begin
          ctl.wptr_inc = 1'b1;
          state_nxt    = S_MRD;
        end
      end
      S_ELRD: begin
        ctl.list_rd  = 1'b1;
        ctl.list_new = 1'b1;
        src_nxt      = SRC_NEW_BLK;
        stat_nxt     = ST_OK;
        last_nxt     = sts.k_last_new;
        state_nxt    = S_OUT;
      end
      S_RWAIT: begin
        ctl.rec_load = 1'b1;
        state_nxt    = S_RCHK;
      end
      S_RCHK: begin
        src_nxt   = SRC_REC;
        stat_nxt  = ST_OK;
        last_nxt  = 1'b1;
        state_nxt = S_OUT;
        unique case (cmd_r)
          CMD_DELETE: begin
            if (sts.rec_ro)        stat_nxt  = ST_RDONLY;
            else if (sts.len_zero) state_nxt = S_DFIN;
            else                   state_nxt = S_DLRD;
          end
          CMD_ATTR: ctl.attr_wr = 1'b1;
          default: begin
            if (sts.slot_bad) begin
              stat_nxt = ST_NOSLOT;
            end else begin
              ctl.list_rd   = 1'b1;
              ctl.list_slot = 1'b1;
              src_nxt       = SRC_REC_BLK;
            end
          end
        endcase
      end
      // release walk: list entry, map word, write back
      S_DLRD: begin
        ctl.list_rd = 1'b1;
        state_nxt   = S_DBLK;
      end
      S_DBLK: begin
        ctl.blk_load = 1'b1;
        state_nxt    = S_DMRD;
      end
      S_DMRD: begin
        ctl.map_rd  = 1'b1;
        ctl.map_blk = 1'b1;
        state_nxt   = S_DFREE;
      end
      S_DFREE: begin
        ctl.free_bit = 1'b1;
        if (sts.k_last_del) begin
          state_nxt = S_DFIN;
        end else begin
          ctl.k_inc = 1'b1;
          state_nxt = S_DLRD;
        end
      end
      S_DFIN: begin
        ctl.del_commit = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            ctl.k_inc = 1'b1;
            state_nxt = S_ELRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

>>> src/file_block_allocator_top.sv
// File block allocator: first-fit inode and data block allocation engine.
// Input words carry a command (create, delete, set attribute, lookup, query)
// on a valid/ready channel; result words leave on a valid/ready channel, the
// final word of each command marked by out_last. Create gives one word per
// allocated block, every other command one word; codes 5 to 7 give none.
// One command is worked at a time; in_ready is high only while idle.
// Create scans for the lowest free inode (one inode per cycle, up to
// INODE_COUNT), then visits the map words from the lowest one, full or
// not; delete walks the block list of the file, one listed block at a time.
// After reset the free map is cleared by a pass over all DATA_BLOCKS/16 map
// words, one map word per cycle, with in_ready low.
// A stalled receiver holds the last word in the output register; the engine
// waits on it and resumes without loss when out_ready returns. The last word
// of a command may wait there while the next command is taken.
// Depends on fab_pkg, fab_ctrl, fab_datapath and fab_ram.
module file_block_allocator_top #(
  parameter int INODE_COUNT     = fab_pkg::DEF_INODE_COUNT,
  parameter int DATA_BLOCKS     = fab_pkg::DEF_DATA_BLOCKS,
  parameter int BLOCKS_PER_FILE = fab_pkg::DEF_BLOCKS_PER_FILE,
  parameter int BLOCK_BYTES     = fab_pkg::DEF_BLOCK_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [25:0] in_file_bytes,
  input  logic [6:0]  in_inode_sel,
  input  logic [1:0]  in_attr_code,
  input  logic [5:0]  in_block_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [6:0]  out_inode_out,
  output logic [11:0] out_block_number,
  output logic        out_block_valid,
  output logic [25:0] out_free_bytes,
  output logic [19:0] out_file_size,
  output logic        out_hidden,
  output logic        out_read_only,
  output logic        out_last
);
  import fab_pkg::*;

  ctl_t ctl;
  sts_t sts;

  fab_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .sts(sts), .ctl(ctl)
  );

  fab_datapath #(
    .INODE_COUNT(INODE_COUNT), .DATA_BLOCKS(DATA_BLOCKS),
    .BLOCKS_PER_FILE(BLOCKS_PER_FILE), .BLOCK_BYTES(BLOCK_BYTES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_file_bytes(in_file_bytes), .in_inode_sel(in_inode_sel),
    .in_attr_code(in_attr_code), .in_block_slot(in_block_slot),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_inode_out(out_inode_out), .out_block_number(out_block_number),
    .out_block_valid(out_block_valid), .out_free_bytes(out_free_bytes),
    .out_file_size(out_file_size), .out_hidden(out_hidden),
    .out_read_only(out_read_only), .out_last(out_last)
  );

`ifndef SYNTH
  // one command at a time: busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // only a successful word carries a block
  a_blk_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_valid |-> out_status == ST_OK)
    else $error("block on failed result");

  // a failure ends the command
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("failure word not last");
`endif
endmodule

>>> tb/tb_file_block_allocator_top.sv
// Testbench for file_block_allocator_top: random and directed commands on a
// valid/ready channel, results checked against a built-in allocation model.
// Depends on fab_pkg and the file_block_allocator_top RTL.
module tb_file_block_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fab_pkg::*;

  localparam int INODES    = DEF_INODE_COUNT;
  localparam int NBLOCKS   = DEF_DATA_BLOCKS;
  localparam int PER_FILE  = DEF_BLOCKS_PER_FILE;
  localparam int BBYTES    = DEF_BLOCK_BYTES;
  localparam int RAND_CMDS = 350;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [25:0] file_bytes;
    logic [6:0]  inode_sel;
    logic [1:0]  attr_code;
    logic [5:0]  block_slot;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  inode_out;
    logic [11:0] block_number;
    logic        block_valid;
    logic [25:0] free_bytes;
    logic [19:0] file_size;
    logic        hidden;
    logic        read_only;
    logic        last;
  } result_word_t;

  // allocation model plus queue of expected result words
  class alloc_scoreboard;
    bit           inode_used[INODES];
    bit           block_free[NBLOCKS];
    int unsigned  free_count;
    logic [11:0]  blk_list[INODES][PER_FILE];
    int unsigned  list_len[INODES];
    logic [19:0]  size_of[INODES];
    bit           hid_of[INODES];
    bit           ro_of[INODES];
    result_word_t expected_words[$];
    int           errors;

    function new();
      for (int i = 0; i < INODES; i++) begin
        inode_used[i] = 0;
        list_len[i] = 0;
        size_of[i] = '0;
        hid_of[i] = 0;
        ro_of[i] = 0;
      end
      for (int b = 0; b < NBLOCKS; b++) block_free[b] = 1;
      free_count = NBLOCKS;
      errors = 0;
    endfunction

    function longint unsigned free_space();
      return longint'(free_count) * BBYTES;
    endfunction

    function void push(logic [2:0] st, int ino, int blk, bit bv, longint unsigned sz,
                       bit h, bit r, bit lst);
      result_word_t w;
      w.status       = st;
      w.inode_out    = ino[6:0];
      w.block_number = blk[11:0];
      w.block_valid  = bv;
      w.free_bytes   = free_space() & 64'h3FFFFFF;
      w.file_size    = sz[19:0];
      w.hidden       = h;
      w.read_only    = r;
      w.last         = lst;
      expected_words.push_back(w);
    endfunction

    function void create_file(logic [25:0] nbytes);
      longint unsigned need;
      int ino, scan, got;
      need = (longint'(nbytes) + BBYTES - 1) / BBYTES;
      if (nbytes > free_space()) begin
        push(ST_NOSPACE, 0, 0, 0, 0, 0, 0, 1);
        return;
      end
      if (need > PER_FILE) begin
        push(ST_TOOLARGE, 0, 0, 0, 0, 0, 0, 1);
        return;
      end
      ino = -1;
      for (int i = 0; i < INODES; i++)
        if (ino < 0 && !inode_used[i]) ino = i;
      if (ino < 0) begin
        push(ST_NOINODE, 0, 0, 0, 0, 0, 0, 1);
        return;
      end
      inode_used[ino] = 1;
      size_of[ino] = nbytes[19:0];
      hid_of[ino] = 0;
      ro_of[ino] = 0;
      scan = 0;
      got = 0;
      // first fit, lowest free block first
      for (int k = 0; k < int'(need); k++) begin
        while (scan < NBLOCKS && !block_free[scan]) scan++;
        if (scan < NBLOCKS) begin
          block_free[scan] = 0;
          if (free_count > 0) free_count--;
          blk_list[ino][got] = scan[11:0];
          got++;
        end
      end
      list_len[ino] = got;
      if (got == 0) push(ST_OK, ino, 0, 0, nbytes, 0, 0, 1);
      for (int k = 0; k < got; k++)
        push(ST_OK, ino, blk_list[ino][k], 1, nbytes, 0, 0, k + 1 == got);
    endfunction

    // work out the result words of one accepted command
    function void note_input(cmd_word_t c);
      int s;
      s = int'(c.inode_sel);
      if (c.cmd == CMD_CREATE) begin
        create_file(c.file_bytes);
        return;
      end
      if (c.cmd == CMD_QUERY) begin
        push(ST_OK, 0, 0, 0, 0, 0, 0, 1);
        return;
      end
      if (c.cmd > CMD_QUERY) return;
      if (!inode_used[s]) begin
        push(ST_NOTUSED, s, 0, 0, 0, 0, 0, 1);
        return;
      end
      case (c.cmd)
        CMD_DELETE: begin
          if (ro_of[s]) begin
            push(ST_RDONLY, s, 0, 0, size_of[s], hid_of[s], ro_of[s], 1);
          end else begin
            for (int i = 0; i < int'(list_len[s]); i++)
              if (!block_free[blk_list[s][i]]) begin
                block_free[blk_list[s][i]] = 1;
                free_count++;
              end
            push(ST_OK, s, 0, 0, size_of[s], hid_of[s], ro_of[s], 1);
            inode_used[s] = 0;
            list_len[s] = 0;
            size_of[s] = '0;
            hid_of[s] = 0;
            ro_of[s] = 0;
          end
        end
        CMD_ATTR: begin
          case (c.attr_code)
            ATTR_SET_HID: hid_of[s] = 1;
            ATTR_CLR_HID: hid_of[s] = 0;
            ATTR_SET_RO:  ro_of[s] = 1;
            default:      ro_of[s] = 0;
          endcase
          push(ST_OK, s, 0, 0, size_of[s], hid_of[s], ro_of[s], 1);
        end
        default: begin
          if (c.block_slot >= list_len[s])
            push(ST_NOSLOT, s, 0, 0, size_of[s], hid_of[s], ro_of[s], 1);
          else
            push(ST_OK, s, blk_list[s][c.block_slot], 1, size_of[s], hid_of[s],
                 ro_of[s], 1);
        end
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 60)
        $display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    task check(result_word_t got);
      result_word_t w;
      if (expected_words.size() == 0) begin
        report("unexpected word", got.status, 0);
        return;
      end
      w = expected_words.pop_front();
      if (got.status !== w.status) report("status", got.status, w.status);
      if (got.inode_out !== w.inode_out) report("inode", got.inode_out, w.inode_out);
      if (got.block_number !== w.block_number)
        report("block_number", got.block_number, w.block_number);
      if (got.block_valid !== w.block_valid)
        report("block_valid", got.block_valid, w.block_valid);
      if (got.free_bytes !== w.free_bytes) report("free_bytes", got.free_bytes, w.free_bytes);
      if (got.file_size !== w.file_size) report("file_size", got.file_size, w.file_size);
      if (got.hidden !== w.hidden) report("hidden", got.hidden, w.hidden);
      if (got.read_only !== w.read_only) report("read_only", got.read_only, w.read_only);
      if (got.last !== w.last) report("last", got.last, w.last);
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_cmd = CMD_QUERY;
  logic [25:0] in_file_bytes = '0;
  logic [6:0]  in_inode_sel = '0;
  logic [1:0]  in_attr_code = ATTR_SET_HID;
  logic [5:0]  in_block_slot = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_status;
  logic [6:0]  out_inode_out;
  logic [11:0] out_block_number;
  logic        out_block_valid;
  logic [25:0] out_free_bytes;
  logic [19:0] out_file_size;
  logic        out_hidden;
  logic        out_read_only;
  logic        out_last;

  alloc_scoreboard sb = new();
  longint cycles = 0;
  bit in_calm = 0;
  bit out_calm = 0;

  file_block_allocator_top DUT (.*);

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // offer one command and wait for its handshake
  task automatic send_cmd(cmd_word_t c);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1;
    in_cmd        <= c.cmd;
    in_file_bytes <= c.file_bytes;
    in_inode_sel  <= c.inode_sel;
    in_attr_code  <= c.attr_code;
    in_block_slot <= c.block_slot;
    do @(posedge clk); while (!in_ready);
    sb.note_input(c);
  endtask

  function automatic cmd_word_t mk(logic [2:0] op, logic [25:0] nb, int sel,
                                   logic [1:0] at, int slot);
    cmd_word_t c;
    c.cmd = op;
    c.file_bytes = nb;
    c.inode_sel = sel[6:0];
    c.attr_code = at;
    c.block_slot = slot[5:0];
    return c;
  endfunction

  // mostly a live inode, sometimes any handle
  function automatic int pick_inode();
    int live[$];
    for (int i = 0; i < INODES; i++) if (sb.inode_used[i]) live.push_back(i);
    if (live.size() == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, INODES - 1);
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic logic [25:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return 26'($urandom_range(1, 3 * BBYTES));
      4, 5:    return 26'($urandom_range(1, PER_FILE * BBYTES));
      6:       return 26'($urandom_range(1, PER_FILE) * BBYTES);
      7:       return 26'(PER_FILE * BBYTES + $urandom_range(0, 1));
      8:       return 26'($urandom);
      default: return 26'($urandom_range(1, PER_FILE) * BBYTES + 1);
    endcase
  endfunction

  function automatic cmd_word_t random_cmd();
    int sel, pick;
    sel = pick_inode();
    pick = $urandom_range(0, 19);
    if (pick < 8)
      return mk(CMD_CREATE, pick_size(), $urandom, 2'($urandom), $urandom);
    if (pick < 12)
      return mk(CMD_DELETE, 26'($urandom), sel, 2'($urandom), $urandom);
    if (pick < 15)
      return mk(CMD_ATTR, 26'($urandom), sel, 2'($urandom), $urandom);
    if (pick < 18)
      return mk(CMD_LOOKUP, 26'($urandom), sel, 2'($urandom),
                ($urandom_range(0, 3) != 0 && sb.list_len[sel] > 0) ?
                $urandom_range(0, sb.list_len[sel] - 1) : $urandom_range(0, 63));
    if (pick < 19)
      return mk(CMD_QUERY, 26'($urandom), $urandom, 2'($urandom), $urandom);
    return mk(3'($urandom_range(5, 7)), 26'($urandom), $urandom, 2'($urandom), $urandom);
  endfunction

  // result side: per-word stall, then check
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      sb.check({out_status, out_inode_out, out_block_number, out_block_valid,
                out_free_bytes, out_file_size, out_hidden, out_read_only, out_last});
    end
  end

  // switch idle behavior in stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) in_calm <= ~in_calm;
    if ($urandom_range(0, 299) == 0) out_calm <= ~out_calm;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: size extremes, every command, every status but ST_NOINODE
    send_cmd(mk(CMD_QUERY, 0, 0, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_CREATE, 0, 0, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_CREATE, 1, 0, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_CREATE, 26'(BBYTES), 0, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_CREATE, 26'(BBYTES + 1), 0, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_CREATE, 26'(PER_FILE * BBYTES), 0, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_CREATE, 26'(PER_FILE * BBYTES + 1), 0, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_CREATE, 26'h3FFFFFF, 0, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_LOOKUP, 0, 4, ATTR_SET_HID, 63));
    send_cmd(mk(CMD_LOOKUP, 0, 4, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_LOOKUP, 0, 0, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_LOOKUP, 0, 127, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_ATTR, 0, 1, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_ATTR, 0, 1, ATTR_SET_RO, 0));
    send_cmd(mk(CMD_DELETE, 0, 1, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_ATTR, 0, 1, ATTR_CLR_HID, 0));
    send_cmd(mk(CMD_ATTR, 0, 1, ATTR_CLR_RO, 0));
    send_cmd(mk(CMD_DELETE, 0, 1, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_DELETE, 0, 1, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_ATTR, 0, 127, ATTR_SET_RO, 0));
    send_cmd(mk(3'd5, 26'h3FFFFFF, 127, ATTR_CLR_RO, 63));
    send_cmd(mk(3'd6, 0, 0, ATTR_SET_HID, 0));
    send_cmd(mk(3'd7, 0, 0, ATTR_SET_HID, 0));
    send_cmd(mk(CMD_QUERY, 26'h3FFFFFF, 127, ATTR_CLR_RO, 63));

    for (int n = 0; n < RAND_CMDS; n++) send_cmd(random_cmd());
    in_valid <= 0;

    // drain, then give the engine time for any stray word
    while (sb.expected_words.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (sb.errors == 0 && sb.expected_words.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
